// ===== rtl/rrps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared constants, register indexes and types of the rounded rectangle
// pixel shader.
// ----------------------------------------------------------------------------
package rrps_pkg;

   // parameter defaults
   localparam int COORD_BITS_DEF       = 16;
   localparam int RADIUS_FRAC_BITS_DEF = 8;

   // fixed field widths
   localparam int PIX_MAX_W   = 16;   // pixel and clip coordinate fields
   localparam int ARGB_W      = 32;
   localparam int ALPHA_W     = 8;
   localparam int RECT_POS_W  = 16;   // signed rectangle origin
   localparam int RECT_SIDE_W = 15;   // rectangle width and height
   localparam int RADIUS_W    = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // signed compare width: holds right/bottom edge (origin + side) and pixel
   localparam int CMP_W = RECT_POS_W + 2;

   // root width of the corner distance: radius stays below 2^(RECT_SIDE_W-1+F)
   localparam int ROOT_W_DEF = RECT_SIDE_W - 1 + RADIUS_FRAC_BITS_DEF;

   localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'hFF;
   localparam logic [ALPHA_W-1:0] ALPHA_ZERO = 8'h00;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_LEFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_TOP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_RADIUS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_X        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_Y        = 3'd7;

   // per-pixel flags and destination value carried along the root pipeline
   typedef struct packed {
      logic              covered;
      logic              corner;
      logic              outside;
      logic [ARGB_W-1:0] dest;
   } side_type;

endpackage
`default_nettype wire

// ===== rtl/rrps_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrps_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband
// record that travels alongside.
// ----------------------------------------------------------------------------
module rrps_isqrt #(
   parameter int ROOT_BITS = rrps_pkg::ROOT_W_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2*ROOT_BITS-1:0]   in_radicand,
   input  rrps_pkg::side_type       in_side,
   output logic                     out_valid,
   output logic [ROOT_BITS-1:0]     out_root,
   output rrps_pkg::side_type       out_side
);
   import rrps_pkg::*;

   localparam int RAD_W = 2 * ROOT_BITS;

   logic                 valid_ff [ROOT_BITS];
   logic [RAD_W-1:0]     rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   side_type             side_ff  [ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
      localparam int K = ROOT_BITS - 1 - j;   // root bit decided here

      logic                 valid_src;
      logic [RAD_W-1:0]     rem_src;
      logic [ROOT_BITS-1:0] root_src;
      side_type             side_src;
      logic [RAD_W-1:0]     trial;
      logic [RAD_W-1:0]     rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_radicand;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign root_src  = root_ff[j-1];
         assign side_src  = side_ff[j-1];
      end

      // (q + 2^K)^2 - q^2 = q*2^(K+1) + 2^(2K); q has no bits at or below K
      assign trial = (RAD_W'(root_src) << (K + 1)) | (RAD_W'(1) << (2 * K));

      always_comb begin
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (ROOT_BITS'(1) << K);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/rrps_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrps_blend
// Two-stage src-over blend of an ARGB8888 source onto the destination with
// shift-by-8 arithmetic; unwritten pixels pass the destination through.
// ----------------------------------------------------------------------------
module rrps_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic                          in_write,
   input  logic [rrps_pkg::ARGB_W-1:0]   in_src,
   input  logic [rrps_pkg::ARGB_W-1:0]   in_dst,
   output logic                          out_valid,
   output logic                          out_write,
   output logic [rrps_pkg::ARGB_W-1:0]   out_pixel
);
   import rrps_pkg::*;

   localparam int PROD_W = 2 * ALPHA_W;

   // stage 1: products
   logic [ALPHA_W-1:0]          sa_c;
   logic [ALPHA_W-1:0]          inv_c;
   logic [PROD_W-1:0]           da_prod_c;
   logic [2:0][PROD_W-1:0]      src_prod_c;
   logic [2:0][PROD_W-1:0]      dst_prod_c;

   logic                        v1_ff;
   logic                        wr1_ff;
   logic [ALPHA_W-1:0]          sa1_ff;
   logic [ARGB_W-1:0]           src1_ff;
   logic [ARGB_W-1:0]           dst1_ff;
   logic [PROD_W-1:0]           da_prod_ff;
   logic [2:0][PROD_W-1:0]      src_prod_ff;
   logic [2:0][PROD_W-1:0]      dst_prod_ff;

   // stage 2: sums and selection
   logic [PROD_W-1:0]           ch_sum_c [3];
   logic [ALPHA_W-1:0]          oa_c;
   logic [ARGB_W-1:0]           blended_c;

   logic                        v2_ff;
   logic                        wr2_ff;
   logic [ARGB_W-1:0]           pix2_ff;

   assign sa_c      = in_src[ARGB_W-1 -: ALPHA_W];
   assign inv_c     = ALPHA_MAX - sa_c;
   assign da_prod_c = PROD_W'(in_dst[ARGB_W-1 -: ALPHA_W]) * PROD_W'(inv_c);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         src_prod_c[c] = PROD_W'(in_src[ALPHA_W*c +: ALPHA_W]) * PROD_W'(sa_c);
         dst_prod_c[c] = PROD_W'(in_dst[ALPHA_W*c +: ALPHA_W]) * PROD_W'(inv_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr1_ff      <= in_write;
         sa1_ff      <= sa_c;
         src1_ff     <= in_src;
         dst1_ff     <= in_dst;
         da_prod_ff  <= da_prod_c;
         src_prod_ff <= src_prod_c;
         dst_prod_ff <= dst_prod_c;
      end
   end

   // each color sum is at most 255*255, so 16 bits never overflow
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch_sum_c[c] = src_prod_ff[c] + dst_prod_ff[c];
      end
   end

   assign oa_c = sa1_ff + da_prod_ff[PROD_W-1 -: ALPHA_W];

   always_comb begin
      if (sa1_ff == ALPHA_ZERO) begin
         blended_c = dst1_ff;
      end else if (sa1_ff == ALPHA_MAX) begin
         blended_c = src1_ff;
      end else begin
         blended_c = {oa_c,
                      ch_sum_c[2][PROD_W-1 -: ALPHA_W],
                      ch_sum_c[1][PROD_W-1 -: ALPHA_W],
                      ch_sum_c[0][PROD_W-1 -: ALPHA_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr2_ff  <= wr1_ff;
         pix2_ff <= wr1_ff ? blended_c : dst1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_write = wr2_ff;
   assign out_pixel = pix2_ff;

endmodule
`default_nettype wire

// ===== rtl/rounded_rect_pixel_shader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rounded_rect_pixel_shader
// Rounded rectangle fill with clip window, corner antialiasing and src-over
// blending, one pixel per clock while req_stall is low.
//
//   port group   direction   handshake          payload
//   req_*        in          req_valid/stall    pixel_x, pixel_y, dest_pixel
//   rsp_*        out         rsp_valid/stall    write_enable, new_pixel
//   csr_*        in          csr_write_en       csr_index, csr_wdata
//
// One request per clock while req_stall is low. The corner distance square
// root resolves one root bit per stage over 14 + RADIUS_FRAC_BITS stages.
// Reset zeroes the configuration, derived settings and valid flags, emptying the pipeline.
// A skid register behind the output lets one more request through after the
// result side stalls; req_stall is that register's full flag.
// ----------------------------------------------------------------------------
module rounded_rect_pixel_shader #(
   parameter int COORD_BITS       = rrps_pkg::COORD_BITS_DEF,
   parameter int RADIUS_FRAC_BITS = rrps_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rrps_pkg::PIX_MAX_W-1:0]   req_pixel_x,
   input  logic [rrps_pkg::PIX_MAX_W-1:0]   req_pixel_y,
   input  logic [rrps_pkg::ARGB_W-1:0]      req_dest_pixel,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_write_enable,
   output logic [rrps_pkg::ARGB_W-1:0]      rsp_new_pixel,

   input  logic                             csr_write_en,
   input  logic [rrps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rrps_pkg::*;

   localparam int PIX_W  = (COORD_BITS < PIX_MAX_W) ? COORD_BITS : PIX_MAX_W;
   localparam int F      = RADIUS_FRAC_BITS;
   localparam int ROOT_W = RECT_SIDE_W - 1 + F;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int FIX_W  = CMP_W + F + 1;
   localparam int RC_W   = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [RECT_POS_W-1:0]  rect_left_ff;
   logic [RECT_POS_W-1:0]  rect_top_ff;
   logic [RECT_SIDE_W-1:0] rect_width_ff;
   logic [RECT_SIDE_W-1:0] rect_height_ff;
   logic [RADIUS_W-1:0]    corner_radius_ff;
   logic [ARGB_W-1:0]      fill_color_ff;
   logic [CSR_DATA_W-1:0]  clip_x_ff;
   logic [CSR_DATA_W-1:0]  clip_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff     <= '0;
         rect_top_ff      <= '0;
         rect_width_ff    <= '0;
         rect_height_ff   <= '0;
         corner_radius_ff <= '0;
         fill_color_ff    <= '0;
         clip_x_ff        <= '0;
         clip_y_ff        <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RECT_LEFT:     rect_left_ff     <= csr_wdata[RECT_POS_W-1:0];
            CSR_RECT_TOP:      rect_top_ff      <= csr_wdata[RECT_POS_W-1:0];
            CSR_RECT_WIDTH:    rect_width_ff    <= csr_wdata[RECT_SIDE_W-1:0];
            CSR_RECT_HEIGHT:   rect_height_ff   <= csr_wdata[RECT_SIDE_W-1:0];
            CSR_CORNER_RADIUS: corner_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_FILL_COLOR:    fill_color_ff    <= csr_wdata[ARGB_W-1:0];
            CSR_CLIP_X:        clip_x_ff        <= csr_wdata;
            CSR_CLIP_Y:        clip_y_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // derived settings, first level: clamped radius, edges, clip bounds
   // ------------------------------------------------------------------------
   logic [RECT_SIDE_W-1:0]    minside_c;
   logic [ROOT_W-1:0]         rmax_c;
   logic [ROOT_W-1:0]         r_c;
   logic signed [CMP_W-1:0]   rl_c, rr_c, rt_c, rb_c;

   logic [ROOT_W-1:0]         r_ff;
   logic                      r_nz_ff;
   logic signed [CMP_W-1:0]   rl_ff, rr_ff, rt_ff, rb_ff;
   logic [PIX_W-1:0]          cl_ff, cr_ff, ct_ff, cb_ff;
   logic                      opaque_ff;

   assign minside_c = (rect_width_ff < rect_height_ff) ? rect_width_ff : rect_height_ff;
   assign rmax_c    = ROOT_W'(minside_c) << (F - 1);
   assign r_c       = (RC_W'(corner_radius_ff) > RC_W'(rmax_c)) ?
                      rmax_c : ROOT_W'(corner_radius_ff);
   assign rl_c      = CMP_W'($signed(rect_left_ff));
   assign rt_c      = CMP_W'($signed(rect_top_ff));
   assign rr_c      = rl_c + $signed(CMP_W'(rect_width_ff));
   assign rb_c      = rt_c + $signed(CMP_W'(rect_height_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff      <= '0;
         r_nz_ff   <= 1'b0;
         rl_ff     <= '0;
         rr_ff     <= '0;
         rt_ff     <= '0;
         rb_ff     <= '0;
         cl_ff     <= '0;
         cr_ff     <= '0;
         ct_ff     <= '0;
         cb_ff     <= '0;
         opaque_ff <= 1'b0;
      end else begin
         r_ff      <= r_c;
         r_nz_ff   <= (r_c != '0);
         rl_ff     <= rl_c;
         rr_ff     <= rr_c;
         rt_ff     <= rt_c;
         rb_ff     <= rb_c;
         cl_ff     <= clip_x_ff[PIX_W-1:0];
         cr_ff     <= clip_x_ff[PIX_MAX_W +: PIX_W];
         ct_ff     <= clip_y_ff[PIX_W-1:0];
         cb_ff     <= clip_y_ff[PIX_MAX_W +: PIX_W];
         opaque_ff <= (fill_color_ff[ARGB_W-1 -: ALPHA_W] == ALPHA_MAX);
      end
   end

   // ------------------------------------------------------------------------
   // derived settings, second level: corner circle centers and radius squared
   // ------------------------------------------------------------------------
   logic signed [FIX_W-1:0]   r_fix;
   logic [SQ_W-1:0]           rsq_c;
   logic signed [FIX_W-1:0]   cxl_ff, cxr_ff, cyt_ff, cyb_ff;
   logic [SQ_W-1:0]           rsq_ff;

   assign r_fix = FIX_W'(r_ff);
   assign rsq_c = SQ_W'(r_ff) * SQ_W'(r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cxl_ff <= '0;
         cxr_ff <= '0;
         cyt_ff <= '0;
         cyb_ff <= '0;
         rsq_ff <= '0;
      end else begin
         cxl_ff <= (FIX_W'(rl_ff) <<< F) + r_fix;
         cxr_ff <= (FIX_W'(rr_ff) <<< F) - r_fix;
         cyt_ff <= (FIX_W'(rt_ff) <<< F) + r_fix;
         cyb_ff <= (FIX_W'(rb_ff) <<< F) - r_fix;
         rsq_ff <= rsq_c;
      end
   end

   // ------------------------------------------------------------------------
   // pipeline control
   // ------------------------------------------------------------------------
   logic en;
   logic skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ------------------------------------------------------------------------
   // stage 0: request register
   // ------------------------------------------------------------------------
   logic              s0_valid_ff;
   logic [PIX_W-1:0]  s0_x_ff, s0_y_ff;
   logic [ARGB_W-1:0] s0_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff    <= req_pixel_x[PIX_W-1:0];
         s0_y_ff    <= req_pixel_y[PIX_W-1:0];
         s0_dest_ff <= req_dest_pixel;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: rectangle and clip coverage
   // ------------------------------------------------------------------------
   logic signed [CMP_W-1:0] px_s, py_s;
   logic                    covered_c;

   logic              s1_valid_ff;
   logic              s1_covered_ff;
   logic [PIX_W-1:0]  s1_x_ff, s1_y_ff;
   logic [ARGB_W-1:0] s1_dest_ff;

   assign px_s = CMP_W'(s0_x_ff);
   assign py_s = CMP_W'(s0_y_ff);

   assign covered_c = (px_s >= rl_ff) && (px_s < rr_ff) &&
                      (py_s >= rt_ff) && (py_s < rb_ff) &&
                      (s0_x_ff >= cl_ff) && (s0_x_ff < cr_ff) &&
                      (s0_y_ff >= ct_ff) && (s0_y_ff < cb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_covered_ff <= covered_c;
         s1_x_ff       <= s0_x_ff;
         s1_y_ff       <= s0_y_ff;
         s1_dest_ff    <= s0_dest_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: corner region and offsets from the corner center
   // ------------------------------------------------------------------------
   logic signed [FIX_W-1:0] fx, fy;
   logic signed [FIX_W-1:0] dl_c, dr_c, dt_c, db_c;
   logic                    lt_l, gt_r, lt_t, gt_b;
   logic                    corner_c;
   logic [ROOT_W-1:0]       dx_c, dy_c;

   logic              s2_valid_ff;
   logic              s2_covered_ff;
   logic              s2_corner_ff;
   logic [ROOT_W-1:0] s2_dx_ff, s2_dy_ff;
   logic [ARGB_W-1:0] s2_dest_ff;

   // pixel center in fixed point
   assign fx = FIX_W'({s1_x_ff, 1'b1, {(F-1){1'b0}}});
   assign fy = FIX_W'({s1_y_ff, 1'b1, {(F-1){1'b0}}});

   assign dl_c = cxl_ff - fx;
   assign dr_c = fx - cxr_ff;
   assign dt_c = cyt_ff - fy;
   assign db_c = fy - cyb_ff;

   assign lt_l = (dl_c > 0);
   assign gt_r = (dr_c > 0);
   assign lt_t = (dt_c > 0);
   assign gt_b = (db_c > 0);

   // left and right regions never overlap since the radius is clamped
   assign corner_c = r_nz_ff && (lt_l || gt_r) && (lt_t || gt_b);
   assign dx_c     = lt_l ? dl_c[ROOT_W-1:0] : dr_c[ROOT_W-1:0];
   assign dy_c     = lt_t ? dt_c[ROOT_W-1:0] : db_c[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_covered_ff <= s1_covered_ff;
         s2_corner_ff  <= corner_c;
         s2_dx_ff      <= dx_c;
         s2_dy_ff      <= dy_c;
         s2_dest_ff    <= s1_dest_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: squares
   // ------------------------------------------------------------------------
   logic              s3_valid_ff;
   logic              s3_covered_ff;
   logic              s3_corner_ff;
   logic [SQ_W-1:0]   s3_dx2_ff, s3_dy2_ff;
   logic [ARGB_W-1:0] s3_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_covered_ff <= s2_covered_ff;
         s3_corner_ff  <= s2_corner_ff;
         s3_dx2_ff     <= SQ_W'(s2_dx_ff) * SQ_W'(s2_dx_ff);
         s3_dy2_ff     <= SQ_W'(s2_dy_ff) * SQ_W'(s2_dy_ff);
         s3_dest_ff    <= s2_dest_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: squared distance
   // ------------------------------------------------------------------------
   logic              s4_valid_ff;
   logic              s4_covered_ff;
   logic              s4_corner_ff;
   logic [SQ_W:0]     s4_dsq_ff;
   logic [ARGB_W-1:0] s4_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_covered_ff <= s3_covered_ff;
         s4_corner_ff  <= s3_corner_ff;
         s4_dsq_ff     <= (SQ_W+1)'(s3_dx2_ff) + (SQ_W+1)'(s3_dy2_ff);
         s4_dest_ff    <= s3_dest_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 5: outside-the-arc test
   // ------------------------------------------------------------------------
   logic            s5_valid_ff;
   side_type        s5_side_ff;
   logic [SQ_W-1:0] s5_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // when inside the arc the distance is below 2^SQ_W, so the root input fits
   always_ff @(posedge clock) begin
      if (en) begin
         s5_side_ff.covered <= s4_covered_ff;
         s5_side_ff.corner  <= s4_corner_ff;
         s5_side_ff.outside <= (s4_dsq_ff > {1'b0, rsq_ff});
         s5_side_ff.dest    <= s4_dest_ff;
         s5_rad_ff          <= s4_dsq_ff[SQ_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // distance: pipelined square root
   // ------------------------------------------------------------------------
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;

   rrps_isqrt #(
      .ROOT_BITS (ROOT_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s5_valid_ff),
      .in_radicand (s5_rad_ff),
      .in_side     (s5_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // ------------------------------------------------------------------------
   // stage 6: edge distance and write decision
   // ------------------------------------------------------------------------
   logic [ROOT_W-1:0] edge_c;

   logic              s6_valid_ff;
   logic              s6_write_ff;
   logic              s6_near_ff;
   logic [F-1:0]      s6_edge_ff;
   logic [ARGB_W-1:0] s6_dest_ff;

   assign edge_c = r_ff - sq_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= sq_valid;
      end
   end

   // near: opaque fill on a corner pixel within one unit of the arc
   always_ff @(posedge clock) begin
      if (en) begin
         s6_write_ff <= sq_side.covered && !(sq_side.corner && sq_side.outside);
         s6_near_ff  <= sq_side.corner && !sq_side.outside && opaque_ff &&
                        (edge_c[ROOT_W-1:F] == '0);
         s6_edge_ff  <= edge_c[F-1:0];
         s6_dest_ff  <= sq_side.dest;
      end
   end

   // ------------------------------------------------------------------------
   // stage 7: antialias alpha and blend source
   // ------------------------------------------------------------------------
   logic [F+ALPHA_W-1:0] edge255_c;
   logic [ALPHA_W-1:0]   alpha_c;

   logic              s7_valid_ff;
   logic              s7_write_ff;
   logic [ARGB_W-1:0] s7_src_ff;
   logic [ARGB_W-1:0] s7_dest_ff;

   assign edge255_c = {s6_edge_ff, {ALPHA_W{1'b0}}} - (F+ALPHA_W)'(s6_edge_ff);
   assign alpha_c   = edge255_c[F+ALPHA_W-1:F];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   // an opaque source blends to itself, so every written pixel goes through
   // the blend
   always_ff @(posedge clock) begin
      if (en) begin
         s7_write_ff <= s6_write_ff;
         s7_src_ff   <= s6_near_ff ? {alpha_c, fill_color_ff[ARGB_W-ALPHA_W-1:0]}
                                   : fill_color_ff;
         s7_dest_ff  <= s6_dest_ff;
      end
   end

   // ------------------------------------------------------------------------
   // blend
   // ------------------------------------------------------------------------
   logic              bl_valid;
   logic              bl_write;
   logic [ARGB_W-1:0] bl_pixel;

   rrps_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_valid_ff),
      .in_write  (s7_write_ff),
      .in_src    (s7_src_ff),
      .in_dst    (s7_dest_ff),
      .out_valid (bl_valid),
      .out_write (bl_write),
      .out_pixel (bl_pixel)
   );

   // ------------------------------------------------------------------------
   // output register and skid register
   // ------------------------------------------------------------------------
   logic              out_free;
   logic              rsp_valid_ff;
   logic              rsp_we_ff;
   logic [ARGB_W-1:0] rsp_pixel_ff;
   logic              skid_we_ff;
   logic [ARGB_W-1:0] skid_pixel_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= bl_valid;
         end
      end else if (!skid_valid_ff) begin
         skid_valid_ff <= bl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_we_ff    <= skid_we_ff;
            rsp_pixel_ff <= skid_pixel_ff;
         end else begin
            rsp_we_ff    <= bl_write;
            rsp_pixel_ff <= bl_pixel;
         end
      end
      if (!skid_valid_ff) begin
         skid_we_ff    <= bl_write;
         skid_pixel_ff <= bl_pixel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_new_pixel    = rsp_pixel_ff;

endmodule
`default_nettype wire
